/* src/jbx_pkg.sv */
package jbx_pkg;

  localparam int FRAMES_DEF        = 1024;
  localparam int PAYLOAD_WORDS_DEF = 20;
  localparam int WORD_BITS         = 64;
  localparam int HEADER_BITS       = 32;
  localparam int PARITY_BIT        = 31;

  typedef enum logic {
    OP_PAYLOAD = 1'b0,
    OP_PLAY    = 1'b1
  } opcode_t;

  // Address width for a store of n entries; a single entry still gets one bit.
  function automatic int addr_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

/* src/jbx_ram.sv */
module jbx_ram #(
  parameter int WIDTH = jbx_pkg::WORD_BITS,
  parameter int DEPTH = jbx_pkg::PAYLOAD_WORDS_DEF,
  localparam int AW   = jbx_pkg::addr_bits(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/jitter_buffer_xor_fec_recovery.sv */
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   opcode, header_seq, word_index, payload_word, last_word
// out_     output     out_valid/out_stall play_seq, play_word, frame_present, last_of_frame
//
// A payload beat only stages its word unless it is a last word whose slot lies inside the buffer.
// That last word then runs through BASE, COPY and VUPD, and through RB too if the pair is rebuilt;
// the staging copy and the XOR rebuild run one word a cycle through the single word unit.
// A playout request runs BASE and PCHK, then PRD and POUT for each word, one frame RAM read per beat.
// After reset the valid store is cleared one slot pair a cycle, all (FRAMES+1)/2 rows.
// out_stall holds the output register; the next item is taken while the last beat still waits.
module jitter_buffer_xor_fec_recovery #(
  parameter int FRAMES        = jbx_pkg::FRAMES_DEF,
  parameter int PAYLOAD_WORDS = jbx_pkg::PAYLOAD_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_opcode,
  input  logic [jbx_pkg::HEADER_BITS-1:0]  in_header_seq,
  input  logic [4:0]                       in_word_index,
  input  logic [jbx_pkg::WORD_BITS-1:0]    in_payload_word,
  input  logic                             in_last_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [jbx_pkg::HEADER_BITS-1:0]  out_play_seq,
  output logic [jbx_pkg::WORD_BITS-1:0]    out_play_word,
  output logic                             out_frame_present,
  output logic                             out_last_of_frame
);

  localparam int ROWS   = (FRAMES + 1) / 2;
  localparam int ROW_W  = jbx_pkg::addr_bits(ROWS);
  localparam int WORD_W = jbx_pkg::addr_bits(PAYLOAD_WORDS);
  localparam int DEPTH  = FRAMES * PAYLOAD_WORDS;
  localparam int ADDR_W = jbx_pkg::addr_bits(DEPTH);
  localparam int WB     = jbx_pkg::WORD_BITS;

  // Bits of one valid row: frame marks, then parity marks, even slot first.
  localparam int VB_FRAME_EVEN = 0;
  localparam int VB_FRAME_ODD  = 1;
  localparam int VB_PAR_ODD    = 3;

  localparam logic [WORD_W-1:0] LAST_IDX = WORD_W'(PAYLOAD_WORDS - 1);
  localparam logic [ADDR_W-1:0] PW_ADDR  = ADDR_W'(PAYLOAD_WORDS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_BASE, S_COPY, S_VUPD, S_RB, S_PCHK, S_PRD, S_POUT
  } state_t;

  state_t              state_r;
  logic [ROW_W-1:0]    row_r;
  logic                lsb_r;
  logic                par_r;
  logic                play_r;
  logic                inr_r;
  logic                odd_ok_r;
  logic                present_r;
  logic [WORD_W-1:0]   cnt_r;
  logic [WORD_W-1:0]   pend_idx_r;
  logic                pend_r;
  logic                mode_rb_r;
  logic [ADDR_W-1:0]   pair_base_r;
  logic [ADDR_W-1:0]   wbase_r;
  logic [ADDR_W-1:0]   rbase_r;
  logic [ADDR_W-1:0]   par_base_r;
  logic [31:0]         play_cnt_r;

  logic                out_valid_r;
  logic [31:0]         out_play_seq_r;
  logic [WB-1:0]       out_play_word_r;
  logic                out_frame_present_r;
  logic                out_last_r;

  logic                in_acc;
  logic [31:0]         key;
  logic [31:0]         key_half;
  logic [31:0]         idx_ext;
  logic                key_in_range;

  logic                stg_we;
  logic [WORD_W-1:0]   stg_waddr;
  logic [WB-1:0]       stg_rdata;

  logic                frame_we;
  logic                parity_we;
  logic [ADDR_W-1:0]   wr_addr;
  logic [WB-1:0]       wr_data;
  logic [WB-1:0]       word_a;
  logic [WB-1:0]       word_b;
  logic [ADDR_W-1:0]   frame_raddr;
  logic [ADDR_W-1:0]   parity_raddr;
  logic [WB-1:0]       frame_rdata;
  logic [WB-1:0]       parity_rdata;

  logic                vld_we;
  logic [3:0]          vld_wdata;
  logic [3:0]          vld_rdata;
  logic [3:0]          vld_set;
  logic [3:0]          vld_upd;
  logic                recover;
  logic                dst_odd;
  logic                beat_free;

  assign in_acc       = in_valid && !in_stall;
  assign in_stall     = (state_r != S_IDLE);
  assign key          = (in_opcode == jbx_pkg::OP_PLAY) ? play_cnt_r
                                                        : {1'b0, in_header_seq[30:0]};
  assign key_half     = key >> 1;
  assign key_in_range = key < 32'(FRAMES);
  assign idx_ext      = 32'(in_word_index);

  assign stg_we    = in_acc && (in_opcode == jbx_pkg::OP_PAYLOAD) &&
                     (idx_ext < 32'(PAYLOAD_WORDS));
  assign stg_waddr = idx_ext[WORD_W-1:0];

  // Shared word unit: a plain copy from staging, or the XOR of a frame and its parity.
  assign word_a    = mode_rb_r ? frame_rdata : stg_rdata;
  assign word_b    = mode_rb_r ? parity_rdata : '0;
  assign wr_data   = word_a ^ word_b;
  assign wr_addr   = wbase_r + ADDR_W'(pend_idx_r);
  assign frame_we  = pend_r && (mode_rb_r || !par_r);
  assign parity_we = pend_r && !mode_rb_r && par_r;

  assign frame_raddr  = rbase_r + ADDR_W'(cnt_r);
  assign parity_raddr = par_base_r + ADDR_W'(cnt_r);

  assign vld_set   = vld_rdata | (4'b0001 << {par_r, lsb_r});
  assign recover   = odd_ok_r && vld_set[VB_PAR_ODD] &&
                     (vld_set[VB_FRAME_EVEN] ^ vld_set[VB_FRAME_ODD]);
  assign dst_odd   = !vld_set[VB_FRAME_ODD];
  assign vld_upd   = recover ? (vld_set | 4'b0011) : vld_set;
  assign vld_we    = (state_r == S_CLEAR) || (state_r == S_VUPD);
  assign vld_wdata = (state_r == S_CLEAR) ? 4'b0000 : vld_upd;

  assign beat_free = !out_valid_r || !out_stall;

  jbx_ram #(.WIDTH(WB), .DEPTH(PAYLOAD_WORDS)) u_stage (
    .clk   (clk),
    .we    (stg_we),
    .waddr (stg_waddr),
    .wdata (in_payload_word),
    .raddr (cnt_r),
    .rdata (stg_rdata)
  );

  jbx_ram #(.WIDTH(WB), .DEPTH(DEPTH)) u_frame (
    .clk   (clk),
    .we    (frame_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (frame_raddr),
    .rdata (frame_rdata)
  );

  jbx_ram #(.WIDTH(WB), .DEPTH(DEPTH)) u_parity (
    .clk   (clk),
    .we    (parity_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (parity_raddr),
    .rdata (parity_rdata)
  );

  jbx_ram #(.WIDTH(4), .DEPTH(ROWS)) u_valid (
    .clk   (clk),
    .we    (vld_we),
    .waddr (row_r),
    .wdata (vld_wdata),
    .raddr (row_r),
    .rdata (vld_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      row_r       <= '0;
      pend_r      <= 1'b0;
      mode_rb_r   <= 1'b0;
      out_valid_r <= 1'b0;
      play_cnt_r  <= '0;
    end else begin
      pend_r     <= (state_r == S_COPY) || (state_r == S_RB);
      pend_idx_r <= cnt_r;
      // The playout state reloads the output register itself when the beat leaves.
      if (out_valid_r && !out_stall && (state_r != S_POUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          row_r <= row_r + ROW_W'(1);
          if (row_r == ROW_W'(ROWS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            play_r   <= (in_opcode == jbx_pkg::OP_PLAY);
            par_r    <= in_header_seq[jbx_pkg::PARITY_BIT];
            lsb_r    <= key[0];
            row_r    <= key_half[ROW_W-1:0];
            inr_r    <= key_in_range;
            odd_ok_r <= (key | 32'd1) < 32'(FRAMES);
            if ((in_opcode == jbx_pkg::OP_PLAY) || (in_last_word && key_in_range)) begin
              state_r <= S_BASE;
            end
          end
        end
        S_BASE: begin
          pair_base_r <= ADDR_W'(32'(row_r) * 32'(2 * PAYLOAD_WORDS));
          wbase_r     <= ADDR_W'(32'({row_r, lsb_r}) * 32'(PAYLOAD_WORDS));
          mode_rb_r   <= 1'b0;
          cnt_r       <= '0;
          state_r     <= play_r ? S_PCHK : S_COPY;
        end
        S_COPY: begin
          cnt_r <= cnt_r + WORD_W'(1);
          if (cnt_r == LAST_IDX) begin
            state_r <= S_VUPD;
          end
        end
        S_VUPD: begin
          // The last staged word is still being written this cycle under the old base.
          wbase_r    <= pair_base_r + (dst_odd ? PW_ADDR : '0);
          rbase_r    <= pair_base_r + (dst_odd ? '0 : PW_ADDR);
          par_base_r <= pair_base_r + PW_ADDR;
          cnt_r      <= '0;
          if (recover) begin
            mode_rb_r <= 1'b1;
            state_r   <= S_RB;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_RB: begin
          if (cnt_r == LAST_IDX) begin
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + WORD_W'(1);
          end
        end
        S_PCHK: begin
          present_r <= inr_r &&
                       (lsb_r ? vld_rdata[VB_FRAME_ODD] : vld_rdata[VB_FRAME_EVEN]);
          rbase_r   <= wbase_r;
          state_r   <= S_PRD;
        end
        S_PRD: begin
          state_r <= S_POUT;
        end
        S_POUT: begin
          if (beat_free) begin
            out_valid_r         <= 1'b1;
            out_play_seq_r      <= play_cnt_r;
            out_play_word_r     <= present_r ? frame_rdata : '0;
            out_frame_present_r <= present_r;
            out_last_r          <= (cnt_r == LAST_IDX);
            if (cnt_r == LAST_IDX) begin
              play_cnt_r <= play_cnt_r + 32'd1;
              state_r    <= S_IDLE;
            end else begin
              cnt_r   <= cnt_r + WORD_W'(1);
              state_r <= S_PRD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_play_seq      = out_play_seq_r;
  assign out_play_word     = out_play_word_r;
  assign out_frame_present = out_frame_present_r;
  assign out_last_of_frame = out_last_r;

`ifndef SYNTHESIS
  a_beat_from_play: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_POUT))
    else $error("result beat loaded outside playout");

  a_rebuild_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (frame_we && mode_rb_r) |-> (wr_addr != frame_raddr))
    else $error("rebuild writes the frame word it is reading");

  a_parity_only_copy: assert property (@(posedge clk) disable iff (!rst_n)
    parity_we |-> (!mode_rb_r && $past(state_r == S_COPY)))
    else $error("parity store written outside the staging copy");

  a_counter_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (play_cnt_r != $past(play_cnt_r))) |->
      ($past(state_r == S_POUT) && out_valid_r && out_last_r))
    else $error("playout counter moved without a final beat");
`endif

endmodule
